FILE: rtl/sorted_list_table_macros.svh
// Assertion macros for the sorted list table checker.
`ifndef SORTED_LIST_TABLE_MACROS_SVH
`define SORTED_LIST_TABLE_MACROS_SVH

// Clocked assertion, disabled while the active-low reset is asserted.
`define SLT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define SLT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/slt_pkg.sv
// Shared types and codes of the sorted list table.
`default_nettype none

package slt_pkg;

  // Request operation codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_FIND   = 2'd2;
  localparam logic [1:0] OP_DUMP   = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  // Command broadcast to every cell of the chain
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_PROBE,
    CELL_DELETE,
    CELL_ROT_L,
    CELL_ROT_R
  } cell_op_e;

  typedef struct packed {
    cell_op_e           op;
    logic signed [31:0] value;
  } cell_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/slt_cell.sv
// One cell of the sorted chain: holds a single value and trades with its neighbors.
`default_nettype none

module slt_cell #(
  parameter int unsigned CW       = 5,
  parameter int unsigned IDX      = 0
) (
  input  wire logic              clk_i,
  input  wire slt_pkg::cell_cmd_t cmd_i,
  input  wire logic [CW-1:0]     count_i,
  input  wire logic signed [31:0] lft_val_i,
  input  wire logic              lft_slot_i,
  input  wire logic signed [31:0] rgt_val_i,
  output logic signed [31:0]     val_o,
  output logic                   slot_o,
  output logic                   match_o
);
  import slt_pkg::*;

  logic signed [31:0] val_q, val_d;
  logic               match_q, ge_q;
  logic               in_use;

  // Occupancy follows from the entry count: cells below it hold live values
  assign in_use = (CW'(IDX) < count_i);

  // Mark a cell that an insert must vacate or fill
  assign slot_o = !in_use || (cmd_i.value < val_q);

  // Pick the next value according to the broadcast command
  always_comb begin
    val_d = val_q;
    unique case (cmd_i.op)
      CELL_INSERT: begin
        if (slot_o) begin
          val_d = lft_slot_i ? lft_val_i : cmd_i.value;
        end
      end
      CELL_DELETE: begin
        if (ge_q) begin
          val_d = rgt_val_i;
        end
      end
      CELL_ROT_L: val_d = rgt_val_i;
      CELL_ROT_R: val_d = lft_val_i;
      default:    val_d = val_q;
    endcase
  end

  // Hold the value and latch compare flags on a probe
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    if (cmd_i.op == CELL_PROBE) begin
      match_q <= in_use && (val_q == cmd_i.value);
      ge_q    <= in_use && !(val_q < cmd_i.value);
    end
  end

  assign val_o   = val_q;
  assign match_o = match_q;

endmodule

`default_nettype wire

FILE: rtl/sorted_list_table.sv
// Top level of the sorted list table: control sequencer around a chain of cells.
`default_nettype none

// Usage:
//   A request (op_i, value_i, descending_i) is taken at a rising edge with start high
//   and busy low. Results appear on result_value_o, status_o and last_o for exactly one
//   cycle, marked by valid_o; the receiver cannot stall them.
//   Insert: one result in the cycle after the request; a new request may follow
//   right away, so inserts run at one per cycle. A full table drops it with status full.
//   Delete and find: the cells compare in the request cycle, the sequencer reduces the
//   match flags in the next one, and the result follows; busy is high for one cycle,
//   so no new request is taken while the flags are reduced.
//   Dump: the chain rotates once around all CAPACITY cells, one step per cycle, and the
//   end cell (first cell for ascending, final cell for descending) is emitted whenever
//   it holds a live entry. A dump keeps busy high through the whole rotation; results come on
//   consecutive cycles, the final one marked by last_o. An empty table gives one result
//   with status empty in the cycle after the request.
//   Reset clears the entry count and the sequencer; cell contents are not cleared and
//   are never read before being written.
module sorted_list_table #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         op_i,
  input  wire logic signed [31:0] value_i,
  input  wire logic               descending_i,
  output logic                    valid_o,
  output logic signed [31:0]      result_value_o,
  output logic [1:0]              status_o,
  output logic                    last_o
);
  import slt_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_PROBE = 2'd1;
  localparam logic [1:0] S_DUMP  = 2'd2;

  logic [1:0]          state_q, state_d;
  logic [CW-1:0]       count_q, count_d;
  logic [CW-1:0]       step_q, step_d;
  logic [CW-1:0]       emit_q, emit_d;
  logic                del_q, del_d;
  logic                desc_q, desc_d;
  logic                valid_q, valid_d;
  logic signed [31:0]  res_q, res_d;
  logic [1:0]          status_q, status_d;
  logic                last_q, last_d;

  cell_cmd_t           cmd;
  logic signed [31:0]  cell_val [CAPACITY];
  logic [CAPACITY-1:0] cell_slot, cell_match;
  logic                accept, found, emit_now;
  logic signed [31:0]  end_val;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);
  assign found  = |cell_match;

  // Chain of cells, closed into a ring for the dump rotation
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam int unsigned L = (i + CAPACITY - 1) % CAPACITY;
    localparam int unsigned R = (i + 1) % CAPACITY;
    slt_cell #(
      .CW      (CW),
      .IDX     (i)
    ) u_cell (
      .clk_i     (clk_i),
      .cmd_i     (cmd),
      .count_i   (count_q),
      .lft_val_i (cell_val[L]),
      .lft_slot_i((i == 0) ? 1'b0 : cell_slot[L]),
      .rgt_val_i (cell_val[R]),
      .val_o     (cell_val[i]),
      .slot_o    (cell_slot[i]),
      .match_o   (cell_match[i])
    );
  end

  // Watched end of the chain during a dump
  assign end_val  = desc_q ? cell_val[CAPACITY-1] : cell_val[0];
  assign emit_now = desc_q ? (step_q >= (CW'(CAPACITY) - count_q)) : (step_q < count_q);

  // Sequence requests and drive the cell commands
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    step_d    = step_q;
    emit_d    = emit_q;
    del_d     = del_q;
    desc_d    = desc_q;
    valid_d   = 1'b0;
    res_d     = '0;
    status_d  = ST_OK;
    last_d    = 1'b1;
    cmd.op    = CELL_HOLD;
    cmd.value = value_i;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (op_i)
            OP_INSERT: begin
              valid_d = 1'b1;
              if (count_q == CW'(CAPACITY)) begin
                status_d = ST_FULL;
              end else begin
                cmd.op  = CELL_INSERT;
                count_d = count_q + CW'(1);
              end
            end
            OP_DELETE, OP_FIND: begin
              cmd.op  = CELL_PROBE;
              del_d   = (op_i == OP_DELETE);
              state_d = S_PROBE;
            end
            default: begin
              if (count_q == '0) begin
                valid_d  = 1'b1;
                status_d = ST_EMPTY;
              end else begin
                desc_d  = descending_i;
                step_d  = '0;
                emit_d  = '0;
                state_d = S_DUMP;
              end
            end
          endcase
        end
      end
      S_PROBE: begin
        valid_d  = 1'b1;
        status_d = found ? ST_OK : ST_NOT_FOUND;
        if (found && del_q) begin
          cmd.op  = CELL_DELETE;
          count_d = count_q - CW'(1);
        end
        state_d = S_IDLE;
      end
      S_DUMP: begin
        cmd.op = desc_q ? CELL_ROT_R : CELL_ROT_L;
        if (emit_now) begin
          valid_d = 1'b1;
          res_d   = end_val;
          last_d  = (emit_q == (count_q - CW'(1)));
          emit_d  = emit_q + CW'(1);
        end
        step_d = step_q + CW'(1);
        if (step_q == CW'(CAPACITY - 1)) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      valid_q <= valid_d;
    end
  end

  // Payload and sequencing registers
  always_ff @(posedge clk_i) begin
    step_q   <= step_d;
    emit_q   <= emit_d;
    del_q    <= del_d;
    desc_q   <= desc_d;
    res_q    <= res_d;
    status_q <= status_d;
    last_q   <= last_d;
  end

  assign valid_o        = valid_q;
  assign result_value_o = res_q;
  assign status_o       = status_q;
  assign last_o         = last_q;

endmodule

`default_nettype wire

FILE: rtl/slt_checker.sv
// Port-level checker for the sorted list table and its bind.
`default_nettype none

`include "sorted_list_table_macros.svh"

module slt_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              start,
  input wire logic              busy,
  input wire logic [1:0]        op_i,
  input wire logic              valid_o,
  input wire logic signed [31:0] result_value_o,
  input wire logic [1:0]        status_o,
  input wire logic              last_o
);
  import slt_pkg::*;

  // A non-ok status is always a single final result with zero value
  `SLT_ASSERT(a_err_last, clk_i, rst_ni, (valid_o && status_o != ST_OK) |-> (last_o && result_value_o == 32'sd0), "error status must be a final zero result")

  // An insert answers in the next cycle
  `SLT_ASSERT(a_ins_lat, clk_i, rst_ni, (start && !busy && op_i == OP_INSERT) |=> (valid_o && last_o), "insert result missing")

  // Delete and find first raise busy, then answer
  `SLT_ASSERT(a_probe_lat, clk_i, rst_ni, (start && !busy && (op_i == OP_DELETE || op_i == OP_FIND)) |=> busy ##1 (valid_o && last_o), "delete or find result missing")

  // A dump streams without gaps until its final result
  `SLT_ASSERT(a_dump_run, clk_i, rst_ni, (valid_o && !last_o) |-> (busy ##1 valid_o), "dump stream broken")

endmodule

bind sorted_list_table slt_checker u_slt_checker (.*);

`default_nettype wire

FILE: bench/tb.sv
// Self-checking bench for the sorted list table: queued requests, a table predictor, result checks.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import slt_pkg::*;

  localparam int unsigned CAPACITY    = 16;
  localparam int unsigned RANDOM_REQS = 380;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct {
    logic [1:0]         op;
    logic signed [31:0] value;
    logic               descending;
    bit                 drain_first;
  } request_t;

  typedef struct {
    logic signed [31:0] value;
    logic [1:0]         status;
    logic               last;
  } result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic [1:0]         op_i = OP_INSERT;
  logic signed [31:0] value_i = '0;
  logic               descending_i = 1'b0;
  logic               busy;
  logic               valid_o;
  logic signed [31:0] result_value_o;
  logic [1:0]         status_o;
  logic               last_o;

  request_t           request_q[$];
  result_t            due_results[$];

  // Predicted table contents
  logic signed [31:0] table_vals [CAPACITY];
  int unsigned        table_count = 0;

  int unsigned        mismatches = 0;
  int unsigned        cycles = 0;
  int unsigned        burst_left = 4;
  int unsigned        gap_left = 0;
  int unsigned        quiet_cycles = 0;

  sorted_list_table #(.CAPACITY(CAPACITY)) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .op_i           (op_i),
    .value_i        (value_i),
    .descending_i   (descending_i),
    .valid_o        (valid_o),
    .result_value_o (result_value_o),
    .status_o       (status_o),
    .last_o         (last_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report(input string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  function automatic void expect_result(logic signed [31:0] v, logic [1:0] st, logic lst);
    result_t r;
    r.value  = v;
    r.status = st;
    r.last   = lst;
    due_results.push_back(r);
  endfunction

  // Apply one accepted request to the predicted table and queue its results
  function automatic void table_update(request_t req);
    int unsigned pos;
    int unsigned hit;
    int unsigned src;
    case (req.op)
      OP_INSERT: begin
        if (table_count >= CAPACITY) begin
          expect_result('0, ST_FULL, 1'b1);
        end else begin
          pos = table_count;
          for (int unsigned i = 0; i < table_count; i++) begin
            if (req.value < table_vals[i]) begin
              pos = i;
              break;
            end
          end
          for (int unsigned i = table_count; i > pos; i--) table_vals[i] = table_vals[i-1];
          table_vals[pos] = req.value;
          table_count++;
          expect_result('0, ST_OK, 1'b1);
        end
      end
      OP_DELETE, OP_FIND: begin
        hit = table_count;
        for (int unsigned i = 0; i < table_count; i++) begin
          if (table_vals[i] == req.value) begin
            hit = i;
            break;
          end
        end
        if (hit == table_count) begin
          expect_result('0, ST_NOT_FOUND, 1'b1);
        end else begin
          if (req.op == OP_DELETE) begin
            for (int unsigned i = hit; i + 1 < table_count; i++) table_vals[i] = table_vals[i+1];
            table_count--;
          end
          expect_result('0, ST_OK, 1'b1);
        end
      end
      default: begin
        if (table_count == 0) begin
          expect_result('0, ST_EMPTY, 1'b1);
        end else begin
          for (int unsigned i = 0; i < table_count; i++) begin
            src = req.descending ? (table_count - 1 - i) : i;
            expect_result(table_vals[src], ST_OK, (i + 1 == table_count));
          end
        end
      end
    endcase
  endfunction

  // Driver: present queued requests in bursts, retire them on acceptance
  always @(posedge clk_i) begin
    logic     accepted;
    logic     present;
    request_t req;
    accepted = 1'b0;
    present  = 1'b0;
    if (rst_ni) begin
      accepted = start && !busy;
      if (accepted) begin
        table_update(request_q.pop_front());
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                   : $urandom_range(1, 24);
        end
      end
      if (start && !accepted) begin
        present = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (request_q.size() != 0) begin
        if (!request_q[0].drain_first) begin
          present = 1'b1;
        end else if (due_results.size() != 0 || busy) begin
          quiet_cycles = 0;
        end else if (quiet_cycles < 4) begin
          quiet_cycles++;
        end else begin
          quiet_cycles = 0;
          present = 1'b1;
        end
      end
      if (present && !(start && !accepted)) begin
        req = request_q[0];
        op_i         <= req.op;
        value_i      <= req.value;
        descending_i <= req.descending;
      end
      start <= present;
    end
  end

  // Monitor: check every strobed result against the oldest prediction
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && valid_o) begin
      if (due_results.size() == 0) begin
        report($sformatf("unexpected result value=%0d status=%0d last=%0b",
                         result_value_o, status_o, last_o));
      end else begin
        want = due_results.pop_front();
        if (result_value_o !== want.value)
          report($sformatf("result_value %0d, predicted %0d", result_value_o, want.value));
        if (status_o !== want.status)
          report($sformatf("status %0d, predicted %0d", status_o, want.status));
        if (last_o !== want.last)
          report($sformatf("last %0b, predicted %0b", last_o, want.last));
      end
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic add_req(logic [1:0] op, logic signed [31:0] v, logic desc, bit drain);
    request_t req;
    req.op          = op;
    req.value       = v;
    req.descending  = desc;
    req.drain_first = drain;
    request_q.push_back(req);
  endtask

  // Stimulus, reset and end of run
  initial begin
    logic signed [31:0] pool [0:9];
    logic signed [31:0] v;
    int unsigned        issued;
    int unsigned        phase_len;
    int unsigned        r;
    bit                 filling;
    bit                 drain;
    logic [1:0]         op;

    // Directed: empty table, extremes, duplicates, ordering, misses
    add_req(OP_DUMP,   32'sd0, 1'b0, 1'b0);
    add_req(OP_DUMP,   32'sd0, 1'b1, 1'b0);
    add_req(OP_FIND,   32'sd0, 1'b0, 1'b0);
    add_req(OP_DELETE, 32'sd0, 1'b1, 1'b0);
    add_req(OP_INSERT, 32'sh7fffffff, 1'b0, 1'b0);
    add_req(OP_INSERT, 32'sh80000000, 1'b1, 1'b0);
    add_req(OP_INSERT, 32'sd0, 1'b0, 1'b0);
    add_req(OP_INSERT, -32'sd1, 1'b0, 1'b0);
    add_req(OP_INSERT, 32'sd1, 1'b0, 1'b0);
    add_req(OP_INSERT, 32'sd7, 1'b0, 1'b0);
    add_req(OP_INSERT, 32'sd7, 1'b1, 1'b0);
    add_req(OP_FIND,   32'sd7, 1'b0, 1'b0);
    add_req(OP_FIND,   32'sd8, 1'b0, 1'b0);
    add_req(OP_FIND,   32'sh80000000, 1'b0, 1'b0);
    add_req(OP_DUMP,   32'sd0, 1'b0, 1'b0);
    add_req(OP_DUMP,   32'sd0, 1'b1, 1'b0);
    add_req(OP_DELETE, 32'sd7, 1'b0, 1'b0);
    add_req(OP_DELETE, 32'sd7, 1'b0, 1'b0);
    add_req(OP_DELETE, 32'sd7, 1'b0, 1'b0);
    add_req(OP_DELETE, 32'sh7fffffff, 1'b0, 1'b0);
    add_req(OP_DELETE, 32'sh80000000, 1'b0, 1'b0);
    add_req(OP_DUMP,   32'sd0, 1'b1, 1'b0);

    // Random: alternate fill-heavy and drain-heavy phases over a small value pool
    issued  = 0;
    filling = 1'b1;
    while (issued < RANDOM_REQS) begin
      for (int i = 0; i < 10; i++) begin
        case ($urandom_range(0, 3))
          0: pool[i] = $urandom;
          1: pool[i] = $signed($urandom_range(0, 20)) - 10;
          2: pool[i] = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
          default: pool[i] = (i == 0) ? 32'sd0 : pool[$urandom_range(0, i - 1)];
        endcase
      end
      phase_len = $urandom_range(20, 50);
      if (phase_len > RANDOM_REQS - issued) phase_len = RANDOM_REQS - issued;
      for (int unsigned k = 0; k < phase_len; k++) begin
        r = $urandom_range(0, 99);
        if (filling)
          op = (r < 70) ? OP_INSERT : (r < 82) ? OP_DELETE : (r < 94) ? OP_FIND : OP_DUMP;
        else
          op = (r < 15) ? OP_INSERT : (r < 65) ? OP_DELETE : (r < 85) ? OP_FIND : OP_DUMP;
        v = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, 9)] : $signed($urandom);
        drain = (issued == 0) || (k == 0 && $urandom_range(0, 2) == 0);
        add_req(op, v, 1'($urandom_range(0, 1)), drain);
        issued++;
      end
      filling = !filling;
    end

    // Hold reset, then release it
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every request to be taken and every result to arrive
    while (request_q.size() != 0 || start) @(posedge clk_i);
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (CAPACITY + 8) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/slt_pkg.sv
rtl/slt_cell.sv
rtl/sorted_list_table.sv
rtl/slt_checker.sv
bench/tb.sv
